### rtl/rsgt_pkg.sv
package rsgt_pkg;

    typedef enum logic [1:0] {
        ACT_FRAME = 2'd0,
        ACT_TICK  = 2'd1,
        ACT_OPEN  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        VERDICT_DELIVER  = 4'd0,
        VERDICT_DUP      = 4'd1,
        VERDICT_STALE    = 4'd2,
        VERDICT_GAP      = 4'd3,
        VERDICT_FWD_NAK  = 4'd4,
        VERDICT_IGN_NAK  = 4'd5,
        VERDICT_FAIL     = 4'd6,
        VERDICT_DOWN     = 4'd7,
        VERDICT_IDLE     = 4'd8,
        VERDICT_OPENED   = 4'd9
    } t_verdict;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_STALE_GRACE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_BUDGET  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NAK_RETRY   = 2'd2;

    localparam logic [15:0] STALE_GRACE_RST = 16'd2000;
    localparam logic [15:0] GAP_BUDGET_RST  = 16'd500;
    localparam logic [15:0] NAK_RETRY_RST   = 16'd100;

    typedef struct packed {
        logic [15:0] grace_window;
        logic [15:0] gap_limit;
        logic [15:0] retry_period;
    } t_cfg;

    typedef struct packed {
        t_action     action;
        logic [31:0] now_ms;
        logic [31:0] frame_session;
        logic [15:0] frame_seq;
        logic        frame_is_nak;
        logic        frame_is_hello;
    } t_item;

    typedef struct packed {
        t_verdict    verdict;
        logic        nak_req;
        logic [15:0] nak_seq;
    } t_result;

endpackage

### rtl/rsgt_in_if.sv
interface rsgt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] now_ms;
    logic [31:0] frame_session;
    logic [15:0] frame_seq;
    logic        frame_is_nak;
    logic        frame_is_hello;

    modport source (
        output valid, action, now_ms, frame_session, frame_seq, frame_is_nak,
               frame_is_hello,
        input  ready
    );
    modport sink (
        input  valid, action, now_ms, frame_session, frame_seq, frame_is_nak,
               frame_is_hello,
        output ready
    );
endinterface

### rtl/rsgt_out_if.sv
interface rsgt_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  verdict;
    logic        nak_req;
    logic [15:0] nak_seq;

    modport source (
        output valid, verdict, nak_req, nak_seq,
        input  ready
    );
    modport sink (
        input  valid, verdict, nak_req, nak_seq,
        output ready
    );
endinterface

### rtl/rx_sequence_gap_tracker.sv
// Receive-side sequence tracker: one verdict per transaction (frame header,
// tick, link open or no-op), one transaction accepted per clock cycle when the
// result side keeps up. The transaction is held in an input register, judged
// combinationally against the link state, and the verdict lands in a result
// register while the link state updates at the same edge, so the next
// transaction already sees it. Configuration writes take effect on the following
// cycle and must only be issued while no transaction is in flight.
module rx_sequence_gap_tracker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rsgt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rsgt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    rsgt_in_if.sink                         i_in,
    rsgt_out_if.source                      o_out
);
    import rsgt_pkg::*;

    t_cfg    cfg;
    t_item   r_in;
    logic    r_in_vld;
    t_result r_out;
    logic    r_out_vld;
    t_result res;
    logic    out_free;
    logic    adv;

    assign out_free   = !r_out_vld || o_out.ready;
    assign adv        = r_in_vld && out_free;
    assign i_in.ready = !r_in_vld || adv;

    rsgt_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    rsgt_tracker u_trk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_vld <= i_in.valid;
            end
            if (out_free) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.action         <= t_action'(i_in.action);
            r_in.now_ms         <= i_in.now_ms;
            r_in.frame_session  <= i_in.frame_session;
            r_in.frame_seq      <= i_in.frame_seq;
            r_in.frame_is_nak   <= i_in.frame_is_nak;
            r_in.frame_is_hello <= i_in.frame_is_hello;
        end
        if (adv) begin
            r_out <= res;
        end
    end

    assign o_out.valid   = r_out_vld;
    assign o_out.verdict = r_out.verdict;
    assign o_out.nak_req = r_out.nak_req;
    assign o_out.nak_seq = r_out.nak_seq;

endmodule

### rtl/rsgt_cfg_regs.sv
module rsgt_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rsgt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rsgt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output rsgt_pkg::t_cfg                 o_cfg
);
    import rsgt_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_STALE_GRACE: n_cfg.grace_window = i_cfg_data;
                CFG_GAP_BUDGET:  n_cfg.gap_limit    = i_cfg_data;
                CFG_NAK_RETRY:   n_cfg.retry_period = i_cfg_data;
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grace_window <= STALE_GRACE_RST;
            r_cfg.gap_limit    <= GAP_BUDGET_RST;
            r_cfg.retry_period <= NAK_RETRY_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/rsgt_tracker.sv
module rsgt_tracker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  rsgt_pkg::t_item   i_item,
    input  rsgt_pkg::t_cfg    i_cfg,
    output rsgt_pkg::t_result o_res
);
    import rsgt_pkg::*;

    logic        r_link_failed, n_link_failed;
    logic        r_session_known, n_session_known;
    logic [31:0] r_peer_session, n_peer_session;
    logic [15:0] r_expected_seq, n_expected_seq;
    logic        r_in_gap, n_in_gap;
    logic [31:0] r_gap_start, n_gap_start;
    logic [31:0] r_last_nak, n_last_nak;
    logic [31:0] r_open_time, n_open_time;

    logic [15:0] seq_diff;
    logic [31:0] since_open;
    logic [31:0] since_gap;
    logic [31:0] since_nak;
    logic        stale_ok;
    logic        gap_expired;
    logic        retry_due;
    logic        sess_zero;
    logic        sess_match;
    t_verdict    verdict;
    logic        nak_req;

    assign seq_diff    = i_item.frame_seq - r_expected_seq;
    assign since_open  = i_item.now_ms - r_open_time;
    assign since_gap   = i_item.now_ms - r_gap_start;
    assign since_nak   = i_item.now_ms - r_last_nak;
    assign stale_ok    = since_open <= {16'd0, i_cfg.grace_window};
    assign gap_expired = since_gap > {16'd0, i_cfg.gap_limit};
    assign retry_due   = since_nak >= {16'd0, i_cfg.retry_period};
    assign sess_zero   = i_item.frame_session == 32'd0;
    assign sess_match  = i_item.frame_session == r_peer_session;

    always_comb begin
        n_link_failed   = r_link_failed;
        n_session_known = r_session_known;
        n_peer_session  = r_peer_session;
        n_expected_seq  = r_expected_seq;
        n_in_gap        = r_in_gap;
        n_gap_start     = r_gap_start;
        n_last_nak      = r_last_nak;
        n_open_time     = r_open_time;
        verdict         = VERDICT_IDLE;
        nak_req         = 1'b0;

        unique case (i_item.action)
            ACT_OPEN: begin
                n_link_failed   = 1'b0;
                n_session_known = 1'b0;
                n_peer_session  = 32'd0;
                n_expected_seq  = 16'd0;
                n_in_gap        = 1'b0;
                n_gap_start     = 32'd0;
                n_last_nak      = 32'd0;
                n_open_time     = i_item.now_ms;
                verdict         = VERDICT_OPENED;
            end
            ACT_NONE: begin
                verdict = VERDICT_IDLE;
            end
            ACT_FRAME: begin
                priority if (r_link_failed) begin
                    verdict = VERDICT_DOWN;
                end else if (sess_zero) begin
                    n_link_failed = 1'b1;
                    verdict       = VERDICT_FAIL;
                end else if (i_item.frame_is_nak) begin
                    verdict = (r_session_known && sess_match) ? VERDICT_FWD_NAK
                                                              : VERDICT_IGN_NAK;
                end else if (!r_session_known) begin
                    if (!i_item.frame_is_hello) begin
                        if (stale_ok) begin
                            verdict = VERDICT_STALE;
                        end else begin
                            n_link_failed = 1'b1;
                            verdict       = VERDICT_FAIL;
                        end
                    end else begin
                        n_session_known = 1'b1;
                        n_peer_session  = i_item.frame_session;
                        n_expected_seq  = i_item.frame_seq + 16'd1;
                        verdict         = VERDICT_DELIVER;
                    end
                end else if (!sess_match) begin
                    n_link_failed = 1'b1;
                    verdict       = VERDICT_FAIL;
                end else if (seq_diff[15]) begin
                    verdict = VERDICT_DUP;
                end else if (seq_diff != 16'd0) begin
                    if (!r_in_gap) begin
                        n_in_gap    = 1'b1;
                        n_gap_start = i_item.now_ms;
                        n_last_nak  = i_item.now_ms;
                        nak_req     = 1'b1;
                    end
                    verdict = VERDICT_GAP;
                end else begin
                    n_expected_seq = r_expected_seq + 16'd1;
                    n_in_gap       = 1'b0;
                    verdict        = VERDICT_DELIVER;
                end
            end
            ACT_TICK: begin
                priority if (r_link_failed) begin
                    verdict = VERDICT_DOWN;
                end else if (r_in_gap && gap_expired) begin
                    n_link_failed = 1'b1;
                    verdict       = VERDICT_FAIL;
                end else if (r_in_gap && retry_due) begin
                    n_last_nak = i_item.now_ms;
                    nak_req    = 1'b1;
                    verdict    = VERDICT_IDLE;
                end else begin
                    verdict = VERDICT_IDLE;
                end
            end
            default: verdict = VERDICT_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_failed   <= 1'b1;
            r_session_known <= 1'b0;
            r_in_gap        <= 1'b0;
        end else if (i_adv) begin
            r_link_failed   <= n_link_failed;
            r_session_known <= n_session_known;
            r_in_gap        <= n_in_gap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_peer_session <= n_peer_session;
            r_expected_seq <= n_expected_seq;
            r_gap_start    <= n_gap_start;
            r_last_nak     <= n_last_nak;
            r_open_time    <= n_open_time;
        end
    end

    assign o_res.verdict = verdict;
    assign o_res.nak_req = nak_req;
    assign o_res.nak_seq = nak_req ? r_expected_seq : 16'd0;

`ifndef SYNTH
    a_open_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_item.action == ACT_OPEN)
        |=> (!r_link_failed && !r_session_known && !r_in_gap))
        else $error("link open left stale state");

    a_gap_needs_session: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_gap |-> r_session_known)
        else $error("gap tracked without a known session");

    a_nak_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        nak_req |-> (verdict == VERDICT_GAP || verdict == VERDICT_IDLE))
        else $error("nak requested with unexpected verdict");

    a_down_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_link_failed && i_adv && i_item.action != ACT_OPEN) |=> r_link_failed)
        else $error("failed link recovered without an open");
`endif

endmodule

### verif/tb_rx_sequence_gap_tracker.sv
`timescale 1ns / 1ps

module tb_rx_sequence_gap_tracker;
    import rsgt_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned PHASE_ITEMS   = 275;
    localparam int unsigned SETTLE_CYCLES = 4;

    class verdict_scoreboard;
        t_cfg        cfg;
        bit          link_failed;
        bit          session_known;
        logic [31:0] peer_session;
        logic [15:0] expected_seq;
        bit          in_gap;
        logic [31:0] gap_start_ms;
        logic [31:0] nak_stamp;
        logic [31:0] open_ms;
        t_result     pending_verdicts[$];
        int unsigned failures;

        function new();
            cfg.grace_window = STALE_GRACE_RST;
            cfg.gap_limit    = GAP_BUDGET_RST;
            cfg.retry_period = NAK_RETRY_RST;
            link_failed = 1'b1;
            clear_link();
            failures = 0;
        endfunction

        function void clear_link();
            session_known = 1'b0;
            peer_session  = '0;
            expected_seq  = '0;
            in_gap        = 1'b0;
            gap_start_ms  = '0;
            nak_stamp     = '0;
            open_ms       = '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_STALE_GRACE: cfg.grace_window = data;
                CFG_GAP_BUDGET:  cfg.gap_limit    = data;
                CFG_NAK_RETRY:   cfg.retry_period = data;
                default: ;
            endcase
        endfunction

        function t_verdict judge_frame(t_item it, output bit nak);
            logic [15:0] seq_diff;
            nak = 1'b0;
            if (it.frame_session == '0) begin
                link_failed = 1'b1;
                return VERDICT_FAIL;
            end
            if (it.frame_is_nak) begin
                if (!session_known || it.frame_session != peer_session)
                    return VERDICT_IGN_NAK;
                return VERDICT_FWD_NAK;
            end
            if (!session_known) begin
                if (!it.frame_is_hello) begin
                    if (it.now_ms - open_ms <= {16'd0, cfg.grace_window})
                        return VERDICT_STALE;
                    link_failed = 1'b1;
                    return VERDICT_FAIL;
                end
                session_known = 1'b1;
                peer_session  = it.frame_session;
                expected_seq  = it.frame_seq + 16'd1;
                return VERDICT_DELIVER;
            end
            if (it.frame_session != peer_session) begin
                link_failed = 1'b1;
                return VERDICT_FAIL;
            end
            seq_diff = it.frame_seq - expected_seq;
            if (seq_diff[15])
                return VERDICT_DUP;
            if (seq_diff != '0) begin
                if (!in_gap) begin
                    in_gap       = 1'b1;
                    gap_start_ms = it.now_ms;
                    nak_stamp    = it.now_ms;
                    nak          = 1'b1;
                end
                return VERDICT_GAP;
            end
            expected_seq = expected_seq + 16'd1;
            in_gap       = 1'b0;
            return VERDICT_DELIVER;
        endfunction

        function t_verdict judge_tick(logic [31:0] now_ms, output bit nak);
            nak = 1'b0;
            if (in_gap) begin
                if (now_ms - gap_start_ms > {16'd0, cfg.gap_limit}) begin
                    link_failed = 1'b1;
                    return VERDICT_FAIL;
                end
                if (now_ms - nak_stamp >= {16'd0, cfg.retry_period}) begin
                    nak_stamp = now_ms;
                    nak       = 1'b1;
                end
            end
            return VERDICT_IDLE;
        endfunction

        function void note_transaction(t_item it);
            t_result res;
            bit      nak;
            nak = 1'b0;
            case (it.action)
                ACT_OPEN: begin
                    clear_link();
                    link_failed = 1'b0;
                    open_ms     = it.now_ms;
                    res.verdict = VERDICT_OPENED;
                end
                ACT_NONE: res.verdict = VERDICT_IDLE;
                default: begin
                    if (link_failed)
                        res.verdict = VERDICT_DOWN;
                    else if (it.action == ACT_FRAME)
                        res.verdict = judge_frame(it, nak);
                    else
                        res.verdict = judge_tick(it.now_ms, nak);
                end
            endcase
            res.nak_req = nak;
            res.nak_seq = nak ? expected_seq : '0;
            pending_verdicts.push_back(res);
        endfunction

        function void check_verdict(t_result got);
            t_result want;
            if (pending_verdicts.size() == 0) begin
                $error("verdict %0d with no transaction pending", got.verdict);
                failures++;
                return;
            end
            want = pending_verdicts.pop_front();
            if (got.verdict !== want.verdict) begin
                $error("verdict: expected %0d, actual %0d", want.verdict, got.verdict);
                failures++;
            end
            if (got.nak_req !== want.nak_req) begin
                $error("nak_req: expected %0d, actual %0d", want.nak_req, got.nak_req);
                failures++;
            end
            if (got.nak_seq !== want.nak_seq) begin
                $error("nak_seq: expected %0h, actual %0h", want.nak_seq, got.nak_seq);
                failures++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    rsgt_in_if  in_if();
    rsgt_out_if out_if();

    rx_sequence_gap_tracker u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    verdict_scoreboard sb;
    bit                steady;
    int unsigned       cycle_count;
    int unsigned       random_count;
    logic [31:0]       link_ms;
    logic [31:0]       peer_guess;
    t_item             seen_item;
    t_result           seen_result;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(negedge i_clk)
        out_if.ready <= steady || ($urandom_range(0, 99) >= 10);

    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready) begin
            seen_item.action         = t_action'(in_if.action);
            seen_item.now_ms         = in_if.now_ms;
            seen_item.frame_session  = in_if.frame_session;
            seen_item.frame_seq      = in_if.frame_seq;
            seen_item.frame_is_nak   = in_if.frame_is_nak;
            seen_item.frame_is_hello = in_if.frame_is_hello;
            sb.note_transaction(seen_item);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            seen_result.verdict = t_verdict'(out_if.verdict);
            seen_result.nak_req = out_if.nak_req;
            seen_result.nak_seq = out_if.nak_seq;
            sb.check_verdict(seen_result);
        end
    end

    function automatic t_item link_item(t_action action, logic [31:0] now_ms,
                                        logic [31:0] session, logic [15:0] seq,
                                        bit is_nak, bit is_hello);
        t_item it;
        it.action         = action;
        it.now_ms         = now_ms;
        it.frame_session  = session;
        it.frame_seq      = seq;
        it.frame_is_nak   = is_nak;
        it.frame_is_hello = is_hello;
        return it;
    endfunction

    task automatic send_item(input t_item it);
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < 10) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid          <= 1'b1;
        in_if.action         <= it.action;
        in_if.now_ms         <= it.now_ms;
        in_if.frame_session  <= it.frame_session;
        in_if.frame_seq      <= it.frame_seq;
        in_if.frame_is_nak   <= it.frame_is_nak;
        in_if.frame_is_hello <= it.frame_is_hello;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic settle();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (sb.pending_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly in-order traffic from one peer, with gaps, duplicates, ticks and noise.
    function automatic t_item make_link_item();
        t_item       it;
        int unsigned roll;
        int unsigned pick;
        int unsigned step_cap;
        step_cap = (sb.cfg.gap_limit >> 2) + 3;
        it.frame_session  = $urandom();
        it.frame_seq      = 16'($urandom());
        it.frame_is_nak   = 1'($urandom_range(0, 1));
        it.frame_is_hello = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 86)
            link_ms = link_ms + $urandom_range(0, step_cap);
        else if (pick < 91)
            link_ms = link_ms + $urandom_range(0, 3 * sb.cfg.gap_limit + 3);
        else if (pick < 94 && sb.in_gap)
            link_ms = sb.gap_start_ms + sb.cfg.gap_limit + $urandom_range(0, 1);
        else if (pick < 97 && sb.in_gap)
            link_ms = sb.nak_stamp + sb.cfg.retry_period - $urandom_range(0, 1);
        else if (pick < 99 && !sb.session_known)
            link_ms = sb.open_ms + sb.cfg.grace_window + $urandom_range(0, 1);
        else if (pick == 99)
            link_ms = $urandom();
        it.now_ms = link_ms;

        roll = $urandom_range(0, 99);
        if ((sb.link_failed && roll < 60) || roll < 2) begin
            it.action  = ACT_OPEN;
            peer_guess = $urandom();
        end else if (roll < 4) begin
            it.action = ACT_NONE;
        end else if (roll < 22 || (sb.in_gap && roll < 40)) begin
            it.action = ACT_TICK;
        end else begin
            it.action = ACT_FRAME;
            pick = $urandom_range(0, 99);
            if (pick < 3)
                it.frame_session = '0;
            else if (pick >= 7)
                it.frame_session = sb.session_known ? sb.peer_session : peer_guess;
            pick = $urandom_range(0, 99);
            it.frame_is_nak = (pick < 5);
            if (pick < 5)
                it.frame_is_hello = 1'($urandom_range(0, 1));
            else if (!sb.session_known)
                it.frame_is_hello = ($urandom_range(0, 99) < 60);
            else
                it.frame_is_hello = ($urandom_range(0, 99) < 3);
            if (sb.session_known) begin
                pick = $urandom_range(0, 99);
                if (pick < (sb.in_gap ? 45 : 78))
                    it.frame_seq = sb.expected_seq;
                else if (pick < 88)
                    it.frame_seq = sb.expected_seq + 16'($urandom_range(1, 8));
                else if (pick < 95)
                    it.frame_seq = sb.expected_seq - 16'($urandom_range(1, 8));
            end
        end
        return it;
    endfunction

    initial begin
        t_item       directed_items[$];
        logic [15:0] phase_grace[6];
        logic [15:0] phase_budget[6];
        logic [15:0] phase_retry[6];

        sb = new();
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = '0;
        i_cfg_data           = '0;
        in_if.valid          = 1'b0;
        in_if.action         = '0;
        in_if.now_ms         = '0;
        in_if.frame_session  = '0;
        in_if.frame_seq      = '0;
        in_if.frame_is_nak   = 1'b0;
        in_if.frame_is_hello = 1'b0;
        out_if.ready         = 1'b1;
        steady               = 1'b0;
        cycle_count          = 0;
        random_count         = 0;
        link_ms              = $urandom();
        peer_guess           = $urandom();

        phase_grace  = '{16'd2000, 16'd0, 16'hFFFF, 16'd0,    16'($urandom()), 16'd150};
        phase_budget = '{16'd500,  16'd0, 16'hFFFF, 16'hFFFF, 16'($urandom()), 16'd300};
        phase_retry  = '{16'd100,  16'd0, 16'hFFFF, 16'd1,
                         16'($urandom_range(1, 65535)), 16'd0};

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed_items = '{
            link_item(ACT_FRAME, 32'd5,          32'd1,          16'd0,      0, 0),
            link_item(ACT_TICK,  32'd6,          32'd1,          16'd0,      0, 0),
            link_item(ACT_NONE,  32'd7,          32'd1,          16'd0,      0, 0),
            link_item(ACT_OPEN,  32'hFFFF_FF00,  32'd0,          16'd0,      0, 0),
            link_item(ACT_FRAME, 32'hFFFF_FF10,  32'd7,          16'd0,      1, 0),
            link_item(ACT_FRAME, 32'h0000_0010,  32'd7,          16'd3,      0, 0),
            link_item(ACT_FRAME, 32'h0000_0011,  32'd7,          16'd3,      1, 1),
            link_item(ACT_FRAME, 32'h0000_0020,  32'hFFFF_FFFF,  16'hFFFF,   0, 1),
            link_item(ACT_FRAME, 32'h0000_0021,  32'hFFFF_FFFF,  16'd0,      0, 0),
            link_item(ACT_FRAME, 32'h0000_0022,  32'hFFFF_FFFF,  16'd0,      0, 0),
            link_item(ACT_FRAME, 32'h0000_0023,  32'hFFFF_FFFF,  16'd0,      1, 0),
            link_item(ACT_FRAME, 32'd0,          32'hFFFF_FFFF,  16'd5,      0, 0),
            link_item(ACT_FRAME, 32'd10,         32'hFFFF_FFFF,  16'd7,      0, 0),
            link_item(ACT_TICK,  32'd99,         32'd0,          16'd0,      0, 0),
            link_item(ACT_TICK,  32'd100,        32'd0,          16'd0,      0, 0),
            link_item(ACT_FRAME, 32'd120,        32'hFFFF_FFFF,  16'd1,      0, 0),
            link_item(ACT_FRAME, 32'd130,        32'hFFFF_FFFF,  16'h8002,   0, 0),
            link_item(ACT_FRAME, 32'd200,        32'hFFFF_FFFF,  16'h8001,   0, 0),
            link_item(ACT_TICK,  32'd700,        32'd0,          16'd0,      0, 0),
            link_item(ACT_TICK,  32'd701,        32'd0,          16'd0,      0, 0),
            link_item(ACT_OPEN,  32'd1000,       32'd0,          16'd0,      0, 0),
            link_item(ACT_FRAME, 32'd1001,       32'd0,          16'd4,      0, 1),
            link_item(ACT_OPEN,  32'd5000,       32'd0,          16'd0,      0, 0),
            link_item(ACT_FRAME, 32'd7001,       32'd9,          16'd4,      0, 0),
            link_item(ACT_OPEN,  32'd8000,       32'd0,          16'd0,      0, 0),
            link_item(ACT_FRAME, 32'd8001,       32'd9,          16'd4,      0, 1),
            link_item(ACT_FRAME, 32'd8002,       32'd10,         16'd5,      0, 0)
        };
        foreach (directed_items[i])
            send_item(directed_items[i]);

        for (int ph = 0; ph < 6; ph++) begin
            settle();
            write_reg(CFG_STALE_GRACE, phase_grace[ph]);
            write_reg(CFG_GAP_BUDGET,  phase_budget[ph]);
            write_reg(CFG_NAK_RETRY,   phase_retry[ph]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                steady = (random_count >= 600 && random_count < 900);
                send_item(make_link_item());
                random_count++;
            end
        end
        steady = 1'b0;

        settle();
        repeat (6) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending_verdicts.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

### rx_sequence_gap_tracker.f
rtl/rsgt_pkg.sv
rtl/rsgt_in_if.sv
rtl/rsgt_out_if.sv
rtl/rsgt_cfg_regs.sv
rtl/rsgt_tracker.sv
rtl/rx_sequence_gap_tracker.sv
verif/tb_rx_sequence_gap_tracker.sv
